FILE: rtl/tpld_pkg.sv
// Shared constants for the two-pole low-pass decimator.
`default_nettype none

package tpld_pkg;

    // Width of the phase increment register.
    localparam int INC_W = 19;

    // Phase increment after reset, native samples per output in Q16.
    localparam logic [INC_W-1:0] INC_RESET = INC_W'(185759);

    // Filter coefficient alpha = ALPHA_NUM / 2**ALPHA_SHIFT.
    localparam int ALPHA_NUM   = 22;
    localparam int ALPHA_SHIFT = 6;

    // Extra bits that the coefficient product needs.
    localparam int ALPHA_BITS = $clog2(ALPHA_NUM + 1);

    // Fraction bits of the filter state.
    localparam int STATE_FRAC = 8;

    // Headroom bits of the filter state above the scaled sample.
    localparam int STATE_HEAD = 2;

    // Register index of the phase increment.
    localparam int REG_PHASE_INC = 0;

    // APB address and data widths.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

endpackage

`default_nettype wire

FILE: rtl/tpld_section.sv
// One-pole low-pass section: state += ((target - state) * alpha) >>> shift.
`default_nettype none

module tpld_section #(
    parameter int W = 26
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic signed [W-1:0] i_target,
    output logic signed [W-1:0]      o_state
);

    localparam int PW = W + 1 + tpld_pkg::ALPHA_BITS;

    logic signed [W-1:0]  r_state;
    logic signed [W-1:0]  n_state;
    logic signed [W:0]    diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    logic signed [W:0]    step;
    logic signed [W:0]    sum;

    // Scaled difference toward the target, floored by the arithmetic shift.
    always_comb begin
        diff    = (W+1)'(i_target) - (W+1)'(r_state);
        prod    = PW'(diff) * PW'(tpld_pkg::ALPHA_NUM);
        shifted = prod >>> tpld_pkg::ALPHA_SHIFT;
        step    = (W+1)'(shifted);
        sum     = (W+1)'(r_state) + step;
        n_state = W'(sum);
    end

    // The state moves once for each item that passes this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

FILE: rtl/tpld_phase.sv
// Fractional phase accumulator that marks the last native sample of each output period.
`default_nettype none

module tpld_phase #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic [tpld_pkg::INC_W-1:0] i_increment,
    output logic                            o_emit
);

    localparam int ACC_W = ((FRAC_BITS > tpld_pkg::INC_W) ? FRAC_BITS : tpld_pkg::INC_W) + 1;
    localparam int CNT_W = ACC_W - FRAC_BITS;

    logic [FRAC_BITS-1:0] r_frac;
    logic [FRAC_BITS-1:0] n_frac;
    logic [CNT_W-1:0]     r_left;
    logic [CNT_W-1:0]     n_left;
    logic [ACC_W-1:0]     acc;
    logic [CNT_W-1:0]     count;
    logic [CNT_W-1:0]     cur;

    // A new period starts when no samples are left; it holds at least one sample.
    always_comb begin
        acc    = ACC_W'(r_frac) + ACC_W'(i_increment);
        count  = acc[ACC_W-1:FRAC_BITS];
        n_frac = r_frac;
        cur    = r_left;
        if (r_left == '0) begin
            n_frac = acc[FRAC_BITS-1:0];
            cur    = (count == '0) ? CNT_W'(1) : count;
        end
        n_left = cur - CNT_W'(1);
        o_emit = (n_left == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= '0;
            r_left <= '0;
        end else if (i_en) begin
            r_frac <= n_frac;
            r_left <= n_left;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/two_pole_lowpass_decimator_top.sv
// Top level of the two-pole low-pass fractional decimator.
//
// Usage: native stereo samples enter on the input channel (i_in_valid,
// o_in_ready, i_left_sample, i_right_sample). Each item is folded to mono,
// passed through two cascaded one-pole low-pass sections, and at the end of
// each output period one filtered sample leaves on the output channel
// (o_out_valid, i_out_ready, o_filtered_sample). Items in the middle of a
// period give no result.
// The period length comes from the Q16 phase increment written over the
// APB port at byte address 0; it must be written only while the block is
// idle; the block itself does not enforce this. Throughput is one item
// per cycle unless the receiver stalls; the pipeline has an input register,
// a first-section stage and a second-section/output stage, and the whole pipeline advances
// together. A result passes the mid-stage flags, then the output register.
// When the receiver stalls with a result waiting, the pipeline holds and
// o_in_ready drops; it stays high as long as the output register is empty
// or being taken. Reset clears both filter sections, the phase and all
// valid flags, and loads the default increment of about 2.834.
`default_nettype none

module two_pole_lowpass_decimator_top #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    // Native sample channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_sample,

    // Filtered sample channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered_sample,

    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tpld_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tpld_pkg::DATA_W-1:0]   pwdata,
    output logic [tpld_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int W  = SAMPLE_BITS + tpld_pkg::STATE_FRAC + tpld_pkg::STATE_HEAD;
    localparam int SW = W - tpld_pkg::STATE_FRAC;
    localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
    localparam int IDX_W = tpld_pkg::ADDR_W - 2;

    logic                          en;
    logic                          reg_sel;
    logic [tpld_pkg::INC_W-1:0]    r_increment;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;

    logic                          r_mid_valid;
    logic                          r_mid_emit;
    logic                          emit;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic signed [SAMPLE_BITS-1:0] n_out;

    logic signed [SAMPLE_BITS:0]   pair_sum;
    logic signed [SAMPLE_BITS-1:0] mono;
    logic signed [W-1:0]           target1;
    logic signed [W-1:0]           first_state;
    logic signed [W-1:0]           second_state;
    logic signed [W-1:0]           n_second;
    logic signed [W-1:0]           second_out;
    logic signed [SW-1:0]          scaled;

    // The pipeline advances unless a result waits and the receiver stalls.
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Configuration register access.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[tpld_pkg::ADDR_W-1:2] == IDX_W'(tpld_pkg::REG_PHASE_INC));
    assign prdata  = reg_sel ? tpld_pkg::DATA_W'(r_increment) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_increment <= tpld_pkg::INC_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_increment <= pwdata[tpld_pkg::INC_W-1:0];
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_in_valid) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
        end
    end

    // Mono fold and Q8 scaling for the first section.
    always_comb begin
        pair_sum = (SAMPLE_BITS+1)'(r_left) + (SAMPLE_BITS+1)'(r_right);
        mono     = SAMPLE_BITS'(pair_sum >>> 1);
        target1  = W'(signed'({mono, {tpld_pkg::STATE_FRAC{1'b0}}}));
    end

    tpld_phase #(
        .FRAC_BITS (FRAC_BITS)
    ) u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en && r_in_valid),
        .i_increment (r_increment),
        .o_emit      (emit)
    );

    tpld_section #(
        .W (W)
    ) u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en && r_in_valid),
        .i_target (target1),
        .o_state  (first_state)
    );

    // Stage flags that follow the item into the second section.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_mid_emit  <= 1'b0;
        end else if (en) begin
            r_mid_valid <= r_in_valid;
            r_mid_emit  <= r_in_valid && emit;
        end
    end

    // The second section follows the first section's state after each item.
    tpld_section #(
        .W (W)
    ) u_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en && r_mid_valid),
        .i_target (first_state),
        .o_state  (second_state)
    );

    // Recompute the second section's next value for the output path.
    always_comb begin
        n_second = second_state
                 + W'(((W+1+tpld_pkg::ALPHA_BITS)'((W+1)'(first_state) - (W+1)'(second_state))
                       * (W+1+tpld_pkg::ALPHA_BITS)'(tpld_pkg::ALPHA_NUM))
                      >>> tpld_pkg::ALPHA_SHIFT);
        second_out = n_second;
        scaled     = SW'(second_out >>> tpld_pkg::STATE_FRAC);
        if (scaled > SMAX) begin
            n_out = SAMPLE_BITS'(SMAX);
        end else if (scaled < SMIN) begin
            n_out = SAMPLE_BITS'(SMIN);
        end else begin
            n_out = SAMPLE_BITS'(scaled);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_mid_valid && r_mid_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_mid_valid && r_mid_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out;

endmodule

`default_nettype wire
